// File: sv/lcdmt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the LCD mode timing controller.
package lcdmt_pkg;

   localparam int unsigned TICKS_W = 8;
   localparam int unsigned LINE_W  = 8;
   localparam int unsigned CMP_W   = 8;
   localparam int unsigned EN_W    = 4;
   localparam int unsigned LEN_W   = 10;
   localparam int unsigned ACC_W   = 11;
   localparam int unsigned CODE_W  = 2;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned ADDR_W  = 4;

   localparam logic [ACC_W-1:0]  ACC_MAX           = 11'd2047;
   localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
   localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

   localparam logic [LEN_W-1:0] OAM_CYCLES_RST    = 10'd80;
   localparam logic [LEN_W-1:0] XFER_CYCLES_RST   = 10'd172;
   localparam logic [LEN_W-1:0] HBLANK_CYCLES_RST = 10'd204;
   localparam logic [LEN_W-1:0] VBLANK_CYCLES_RST = 10'd456;

   // status enable bits
   localparam int unsigned EN_HBLANK  = 0;
   localparam int unsigned EN_VBLANK  = 1;
   localparam int unsigned EN_OAM     = 2;
   localparam int unsigned EN_COMPARE = 3;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_OAM    = 2'd0;
   localparam logic [1:0] REG_XFER   = 2'd1;
   localparam logic [1:0] REG_HBLANK = 2'd2;
   localparam logic [1:0] REG_VBLANK = 2'd3;

   // mode codes as seen on the result channel
   localparam logic [CODE_W-1:0] CODE_HBLANK = 2'd0;
   localparam logic [CODE_W-1:0] CODE_VBLANK = 2'd1;
   localparam logic [CODE_W-1:0] CODE_OAM    = 2'd2;
   localparam logic [CODE_W-1:0] CODE_XFER   = 2'd3;

   typedef enum logic [3:0] {
      MODE_HBLANK = 4'b0001,
      MODE_VBLANK = 4'b0010,
      MODE_OAM    = 4'b0100,
      MODE_XFER   = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [LEN_W-1:0] oam_cycles;
      logic [LEN_W-1:0] xfer_cycles;
      logic [LEN_W-1:0] hblank_len;
      logic [LEN_W-1:0] vblank_len;
   } cfg_type;

   typedef struct packed {
      logic [TICKS_W-1:0] ticks;
      logic               lcd_on;
      logic               lcd_restart;
      logic [CMP_W-1:0]   line_compare;
      logic [EN_W-1:0]    stat_enables;
   } item_type;

   typedef struct packed {
      logic [ACC_W-1:0]  acc;
      mode_type          mode;
      logic [LINE_W-1:0] line;
      logic              match;
   } state_type;

   typedef struct packed {
      logic [CODE_W-1:0] mode;
      logic [LINE_W-1:0] line;
      logic              line_match;
      logic              stat_irq;
      logic              vblank_irq;
      logic              render_line;
      logic              frame_done;
   } result_type;

   function automatic logic [CODE_W-1:0] mode_code(mode_type m);
      logic [CODE_W-1:0] c;
      case (m)
         MODE_HBLANK: c = CODE_HBLANK;
         MODE_VBLANK: c = CODE_VBLANK;
         MODE_OAM:    c = CODE_OAM;
         MODE_XFER:   c = CODE_XFER;
         default:     c = CODE_HBLANK;
      endcase
      return c;
   endfunction

endpackage

// File: sv/lcdmt_req_if.sv
`timescale 1ns / 1ps
// Input channel interface: tick item with valid/ready handshake.
interface lcdmt_req_if;
   logic                            valid;
   logic                            ready;
   logic [lcdmt_pkg::TICKS_W-1:0]   ticks;
   logic                            lcd_on;
   logic                            lcd_restart;
   logic [lcdmt_pkg::CMP_W-1:0]     line_compare;
   logic [lcdmt_pkg::EN_W-1:0]      stat_enables;

   modport source (output valid, ticks, lcd_on, lcd_restart, line_compare, stat_enables,
                   input ready);
   modport sink   (input valid, ticks, lcd_on, lcd_restart, line_compare, stat_enables,
                   output ready);
endinterface

// File: sv/lcdmt_rsp_if.sv
`timescale 1ns / 1ps
// Result channel interface: mode, line and request pulses with valid/ready handshake.
interface lcdmt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lcdmt_pkg::CODE_W-1:0]    mode;
   logic [lcdmt_pkg::LINE_W-1:0]    line;
   logic                            line_match;
   logic                            stat_irq;
   logic                            vblank_irq;
   logic                            render_line;
   logic                            frame_done;

   modport source (output valid, mode, line, line_match, stat_irq, vblank_irq,
                   render_line, frame_done,
                   input ready);
   modport sink   (input valid, mode, line, line_match, stat_irq, vblank_irq,
                   render_line, frame_done,
                   output ready);
endinterface

// File: sv/lcdmt_csr.sv
`timescale 1ns / 1ps
// APB-style register file holding the four mode lengths.
module lcdmt_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lcdmt_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [lcdmt_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [lcdmt_pkg::DATA_W-1:0]   csr_prdata,
   output logic                           csr_pready,
   output lcdmt_pkg::cfg_type             cfg
);

   lcdmt_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0] idx;
   logic [lcdmt_pkg::LEN_W-1:0] wval, rval;
   logic wr;

   assign idx  = csr_paddr[3:2];
   assign wval = csr_pwdata[lcdmt_pkg::LEN_W-1:0];
   assign wr   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            lcdmt_pkg::REG_OAM:    cfg_in.oam_cycles  = wval;
            lcdmt_pkg::REG_XFER:   cfg_in.xfer_cycles = wval;
            lcdmt_pkg::REG_HBLANK: cfg_in.hblank_len  = wval;
            lcdmt_pkg::REG_VBLANK: cfg_in.vblank_len  = wval;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.oam_cycles  <= lcdmt_pkg::OAM_CYCLES_RST;
         cfg_ff.xfer_cycles <= lcdmt_pkg::XFER_CYCLES_RST;
         cfg_ff.hblank_len  <= lcdmt_pkg::HBLANK_CYCLES_RST;
         cfg_ff.vblank_len  <= lcdmt_pkg::VBLANK_CYCLES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         lcdmt_pkg::REG_OAM:    rval = cfg_ff.oam_cycles;
         lcdmt_pkg::REG_XFER:   rval = cfg_ff.xfer_cycles;
         lcdmt_pkg::REG_HBLANK: rval = cfg_ff.hblank_len;
         lcdmt_pkg::REG_VBLANK: rval = cfg_ff.vblank_len;
         default:               rval = '0;
      endcase
   end

   assign csr_prdata = lcdmt_pkg::DATA_W'(rval);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// File: sv/lcdmt_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one tick item.
module lcdmt_step (
   input  lcdmt_pkg::cfg_type     cfg,
   input  lcdmt_pkg::item_type    item,
   input  lcdmt_pkg::state_type   cur,
   output lcdmt_pkg::state_type   nxt,
   output lcdmt_pkg::result_type  res
);

   logic [lcdmt_pkg::ACC_W:0]    sum;
   logic [lcdmt_pkg::ACC_W-1:0]  acc;
   logic [lcdmt_pkg::LINE_W-1:0] line_adv;
   logic                         hit;
   logic                         stat, vbl, rend, frame;

   // line after a line change, wrapping past the last vblank line
   assign line_adv = (cur.line >= lcdmt_pkg::LAST_LINE) ? '0 : cur.line + 8'd1;
   assign hit      = (line_adv == item.line_compare);

   always_comb begin
      nxt   = cur;
      stat  = 1'b0;
      vbl   = 1'b0;
      rend  = 1'b0;
      frame = 1'b0;
      if (item.lcd_restart) begin
         nxt.acc  = '0;
         nxt.mode = lcdmt_pkg::MODE_HBLANK;
      end
      sum = {1'b0, nxt.acc} + (lcdmt_pkg::ACC_W + 1)'(item.ticks);
      acc = sum[lcdmt_pkg::ACC_W] ? lcdmt_pkg::ACC_MAX : sum[lcdmt_pkg::ACC_W-1:0];
      if (item.lcd_on) begin
         nxt.acc = acc;
         case (nxt.mode)
            lcdmt_pkg::MODE_OAM: begin
               if (acc >= lcdmt_pkg::ACC_W'(cfg.oam_cycles)) begin
                  nxt.acc  = '0;
                  nxt.mode = lcdmt_pkg::MODE_XFER;
               end
            end
            lcdmt_pkg::MODE_XFER: begin
               if (acc >= lcdmt_pkg::ACC_W'(cfg.xfer_cycles)) begin
                  nxt.acc  = '0;
                  nxt.mode = lcdmt_pkg::MODE_HBLANK;
                  rend     = 1'b1;
                  stat     = item.stat_enables[lcdmt_pkg::EN_HBLANK];
               end
            end
            lcdmt_pkg::MODE_HBLANK: begin
               if (acc >= lcdmt_pkg::ACC_W'(cfg.hblank_len)) begin
                  nxt.acc   = '0;
                  nxt.line  = line_adv;
                  nxt.match = hit;
                  if (line_adv == lcdmt_pkg::FIRST_VBLANK_LINE) begin
                     nxt.mode = lcdmt_pkg::MODE_VBLANK;
                     vbl      = 1'b1;
                     stat     = item.stat_enables[lcdmt_pkg::EN_VBLANK];
                  end else begin
                     nxt.mode = lcdmt_pkg::MODE_OAM;
                     stat     = item.stat_enables[lcdmt_pkg::EN_OAM];
                  end
                  stat = stat | (hit && item.stat_enables[lcdmt_pkg::EN_COMPARE]);
               end
            end
            default: begin
               if (acc >= lcdmt_pkg::ACC_W'(cfg.vblank_len)) begin
                  nxt.acc   = '0;
                  nxt.line  = line_adv;
                  nxt.match = hit;
                  if (line_adv == '0) begin
                     nxt.mode = lcdmt_pkg::MODE_OAM;
                     frame    = 1'b1;
                     stat     = item.stat_enables[lcdmt_pkg::EN_OAM];
                  end
                  stat = stat | (hit && item.stat_enables[lcdmt_pkg::EN_COMPARE]);
               end
            end
         endcase
      end
   end

   always_comb begin
      res.mode        = lcdmt_pkg::mode_code(nxt.mode);
      res.line        = nxt.line;
      res.line_match  = nxt.match;
      res.stat_irq    = stat;
      res.vblank_irq  = vbl;
      res.render_line = rend;
      res.frame_done  = frame;
   end

endmodule

// File: sv/lcd_mode_timing_controller.sv
`timescale 1ns / 1ps
// Top level of the LCD mode timing controller.
//
//   channel  ports        direction  carries
//   -------  -----------  ---------  ----------------------------------------
//   input    req_ch       sink       ticks, lcd_on, lcd_restart, compare, enables
//   result   rsp_ch       source     mode, line, match flag, four request pulses
//   config   csr_*        APB slave  four 10-bit mode lengths at 0x0..0xC
//
// One item per cycle sustained while the result channel is not stalled; an accepted item
// passes the input register, then the mode/line update into the result register.
// Reset is synchronous: mode hblank, line 0, accumulator and match flag cleared,
// lengths at their defaults. A stalled result holds in the output register; the input
// register still takes a new item in the cycle the result is taken.
module lcd_mode_timing_controller (
   input  logic                           clock,
   input  logic                           reset,
   lcdmt_req_if.sink                      req_ch,
   lcdmt_rsp_if.source                    rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lcdmt_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [lcdmt_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [lcdmt_pkg::DATA_W-1:0]   csr_prdata,
   output logic                           csr_pready
);

   lcdmt_pkg::cfg_type    cfg;
   lcdmt_pkg::item_type   item_ff, item_in;
   lcdmt_pkg::state_type  state_ff, state_nxt;
   lcdmt_pkg::result_type res_ff, res_nxt;
   logic                  item_vld_ff, item_vld_in;
   logic                  res_vld_ff, res_vld_in;
   logic                  advance, take;

   lcdmt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lcdmt_step u_step (
      .cfg  (cfg),
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_nxt),
      .res  (res_nxt)
   );

   assign advance      = item_vld_ff && (!res_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !item_vld_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      item_in.ticks        = req_ch.ticks;
      item_in.lcd_on       = req_ch.lcd_on;
      item_in.lcd_restart  = req_ch.lcd_restart;
      item_in.line_compare = req_ch.line_compare;
      item_in.stat_enables = req_ch.stat_enables;
      item_vld_in = take || (item_vld_ff && !advance);
      res_vld_in  = advance || (res_vld_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         res_vld_ff  <= 1'b0;
         state_ff    <= '{acc: '0, mode: lcdmt_pkg::MODE_HBLANK, line: '0, match: 1'b0};
      end else begin
         item_vld_ff <= item_vld_in;
         res_vld_ff  <= res_vld_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= res_nxt;
      end
   end

   assign rsp_ch.valid       = res_vld_ff;
   assign rsp_ch.mode        = res_ff.mode;
   assign rsp_ch.line        = res_ff.line;
   assign rsp_ch.line_match  = res_ff.line_match;
   assign rsp_ch.stat_irq    = res_ff.stat_irq;
   assign rsp_ch.vblank_irq  = res_ff.vblank_irq;
   assign rsp_ch.render_line = res_ff.render_line;
   assign rsp_ch.frame_done  = res_ff.frame_done;

   a_mode_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.mode))
      else $error("mode register lost its one-hot code");

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.line <= lcdmt_pkg::LAST_LINE))
      else $error("result line beyond last line");

   a_vblank_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.vblank_irq) |->
         (rsp_ch.line == lcdmt_pkg::FIRST_VBLANK_LINE && rsp_ch.mode == lcdmt_pkg::CODE_VBLANK))
      else $error("vblank request away from first vblank line");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_done) |->
         (rsp_ch.line == '0 && rsp_ch.mode == lcdmt_pkg::CODE_OAM))
      else $error("frame end without wrap to line zero in oam search");

   a_accept_flow: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> item_vld_ff)
      else $error("accepted item not held in input register");

endmodule

// File: verif/lcd_mode_timing_controller_tb.sv
`timescale 1ns / 1ps
// Testbench for the LCD mode timing controller: directed table and random items, scoreboarded.
module lcd_mode_timing_controller_tb;

   localparam int DIR_ROWS = 19;
   localparam int PHASES = 8;
   localparam int MAX_PRINTS = 40;
   localparam lcdmt_pkg::result_type PREDICTED = '0;

   typedef logic [lcdmt_pkg::LEN_W-1:0] len_type;

   typedef struct packed {
      lcdmt_pkg::item_type   stim;
      logic                  typed;
      lcdmt_pkg::result_type want;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [lcdmt_pkg::ADDR_W-1:0] csr_paddr;
   logic [lcdmt_pkg::DATA_W-1:0] csr_pwdata;
   logic [lcdmt_pkg::DATA_W-1:0] csr_prdata;
   logic csr_pready;

   lcdmt_req_if req_bus ();
   lcdmt_rsp_if rsp_bus ();

   lcd_mode_timing_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // mirror of the block's timing state
   logic [lcdmt_pkg::ACC_W-1:0]  acc_m;
   logic [lcdmt_pkg::CODE_W-1:0] mode_m;
   logic [lcdmt_pkg::LINE_W-1:0] line_m;
   logic                         match_m;
   lcdmt_pkg::cfg_type           len_m;

   lcdmt_pkg::result_type pending_results[$];
   dir_row_type           dir_table[DIR_ROWS];
   logic                  row_typed;
   lcdmt_pkg::result_type row_want;
   int                    send_gap_pct;
   int                    stall_pct;
   int                    mismatches;
   int                    results_seen;
   int                    frames_seen;
   int                    vblanks_seen;
   int                    restarts_sent;
   int                    random_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic lcdmt_pkg::result_type advance_timing(lcdmt_pkg::item_type it);
      lcdmt_pkg::result_type r;
      logic [lcdmt_pkg::ACC_W:0] sum;
      logic line_moved;
      r = '0;
      line_moved = 1'b0;
      if (it.lcd_restart) begin
         acc_m = '0;
         mode_m = lcdmt_pkg::CODE_HBLANK;
      end
      if (it.lcd_on) begin
         sum = acc_m + it.ticks;
         acc_m = (sum > lcdmt_pkg::ACC_MAX) ? lcdmt_pkg::ACC_MAX : sum[lcdmt_pkg::ACC_W-1:0];
         case (mode_m)
            lcdmt_pkg::CODE_OAM: begin
               if (acc_m >= len_m.oam_cycles) begin
                  acc_m = '0;
                  mode_m = lcdmt_pkg::CODE_XFER;
               end
            end
            lcdmt_pkg::CODE_XFER: begin
               if (acc_m >= len_m.xfer_cycles) begin
                  acc_m = '0;
                  r.render_line = 1'b1;
                  r.stat_irq = it.stat_enables[lcdmt_pkg::EN_HBLANK];
                  mode_m = lcdmt_pkg::CODE_HBLANK;
               end
            end
            lcdmt_pkg::CODE_HBLANK: begin
               if (acc_m >= len_m.hblank_len) begin
                  acc_m = '0;
                  line_moved = 1'b1;
                  line_m = (line_m == lcdmt_pkg::LAST_LINE) ? '0 : line_m + 1'b1;
                  if (line_m == lcdmt_pkg::FIRST_VBLANK_LINE) begin
                     mode_m = lcdmt_pkg::CODE_VBLANK;
                     r.vblank_irq = 1'b1;
                     r.stat_irq = it.stat_enables[lcdmt_pkg::EN_VBLANK];
                  end else begin
                     mode_m = lcdmt_pkg::CODE_OAM;
                     r.stat_irq = it.stat_enables[lcdmt_pkg::EN_OAM];
                  end
               end
            end
            default: begin
               if (acc_m >= len_m.vblank_len) begin
                  acc_m = '0;
                  line_moved = 1'b1;
                  if (line_m == lcdmt_pkg::LAST_LINE) begin
                     line_m = '0;
                     mode_m = lcdmt_pkg::CODE_OAM;
                     r.frame_done = 1'b1;
                     r.stat_irq = it.stat_enables[lcdmt_pkg::EN_OAM];
                  end else begin
                     line_m = line_m + 1'b1;
                  end
               end
            end
         endcase
         if (line_moved) begin
            match_m = (line_m == it.line_compare);
            r.stat_irq = r.stat_irq | (match_m & it.stat_enables[lcdmt_pkg::EN_COMPARE]);
         end
      end
      r.mode = mode_m;
      r.line = line_m;
      r.line_match = match_m;
      return r;
   endfunction

   // mostly well-formed running display, with restarts steered into late vblank
   function automatic lcdmt_pkg::item_type random_item();
      lcdmt_pkg::item_type it;
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) it.ticks = '0;
      else if (pick < 20) it.ticks = '1;
      else it.ticks = $urandom_range(255);
      it.lcd_on = ($urandom_range(99) >= 5);
      if (!it.lcd_on) it.lcd_restart = $urandom_range(1);
      else if (mode_m == lcdmt_pkg::CODE_VBLANK && line_m >= lcdmt_pkg::LAST_LINE - 3)
         it.lcd_restart = ($urandom_range(3) == 0);
      else it.lcd_restart = ($urandom_range(99) < 2);
      if ($urandom_range(99) < 40) it.line_compare = line_m + 1'b1;
      else it.line_compare = $urandom_range(255);
      it.stat_enables = $urandom_range(15);
      return it;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatches < MAX_PRINTS)
         $display("%0t: mismatch on %s at result %0d: got %0d, expected %0d",
                  $realtime, what, results_seen, got, want);
      mismatches++;
   endtask

   // starts and ends at a falling edge
   task automatic send_item(lcdmt_pkg::item_type it, logic typed, lcdmt_pkg::result_type want);
      if ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_bus.valid        <= 1'b1;
      req_bus.ticks        <= it.ticks;
      req_bus.lcd_on       <= it.lcd_on;
      req_bus.lcd_restart  <= it.lcd_restart;
      req_bus.line_compare <= it.line_compare;
      req_bus.stat_enables <= it.stat_enables;
      row_typed <= typed;
      row_want  <= want;
      if (it.lcd_restart) restarts_sent++;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // setup, access, then back to idle; starts and ends at a falling edge
   task automatic write_length(logic [1:0] idx, len_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= ($urandom() << lcdmt_pkg::LEN_W) | value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         lcdmt_pkg::REG_OAM:    len_m.oam_cycles  = value;
         lcdmt_pkg::REG_XFER:   len_m.xfer_cycles = value;
         lcdmt_pkg::REG_HBLANK: len_m.hblank_len  = value;
         lcdmt_pkg::REG_VBLANK: len_m.vblank_len  = value;
         default:               ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   always @(negedge clock) rsp_bus.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : scoreboard
      lcdmt_pkg::result_type got;
      lcdmt_pkg::result_type want;
      lcdmt_pkg::item_type   taken;
      lcdmt_pkg::result_type pred;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.mode, rsp_bus.line, rsp_bus.line_match, rsp_bus.stat_irq,
                   rsp_bus.vblank_irq, rsp_bus.render_line, rsp_bus.frame_done};
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               want = pending_results.pop_front();
               if (got.mode != want.mode) report_mismatch("mode", got.mode, want.mode);
               if (got.line != want.line) report_mismatch("line", got.line, want.line);
               if (got.line_match != want.line_match)
                  report_mismatch("line_match", got.line_match, want.line_match);
               if (got.stat_irq != want.stat_irq)
                  report_mismatch("stat_irq", got.stat_irq, want.stat_irq);
               if (got.vblank_irq != want.vblank_irq)
                  report_mismatch("vblank_irq", got.vblank_irq, want.vblank_irq);
               if (got.render_line != want.render_line)
                  report_mismatch("render_line", got.render_line, want.render_line);
               if (got.frame_done != want.frame_done)
                  report_mismatch("frame_done", got.frame_done, want.frame_done);
               frames_seen  += want.frame_done;
               vblanks_seen += want.vblank_irq;
            end
            results_seen++;
         end
         if (req_bus.valid && req_bus.ready) begin
            taken = {req_bus.ticks, req_bus.lcd_on, req_bus.lcd_restart,
                     req_bus.line_compare, req_bus.stat_enables};
            pred = advance_timing(taken);
            pending_results.push_back(row_typed ? row_want : pred);
         end
      end
   end

   initial begin
      lcdmt_pkg::cfg_type next_len;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.ticks = '0;
      req_bus.lcd_on = 1'b0;
      req_bus.lcd_restart = 1'b0;
      req_bus.line_compare = '0;
      req_bus.stat_enables = '0;
      rsp_bus.ready = 1'b0;
      row_typed = 1'b0;
      row_want = '0;
      send_gap_pct = 0;
      stall_pct = 0;
      mismatches = 0;
      results_seen = 0;
      frames_seen = 0;
      vblanks_seen = 0;
      restarts_sent = 0;
      random_sent = 0;
      acc_m = '0;
      mode_m = lcdmt_pkg::CODE_HBLANK;
      line_m = '0;
      match_m = 1'b0;
      len_m = {lcdmt_pkg::OAM_CYCLES_RST, lcdmt_pkg::XFER_CYCLES_RST,
               lcdmt_pkg::HBLANK_CYCLES_RST, lcdmt_pkg::VBLANK_CYCLES_RST};

      // ticks, on, restart, compare, enables | typed | mode, line, match/stat/vbl/render/frame
      dir_table = '{
         {8'd0,   1'b0, 1'b0, 8'd0,   4'h0, 1'b1, lcdmt_pkg::CODE_HBLANK, 8'd0, 5'b00000},
         {8'd255, 1'b0, 1'b1, 8'd255, 4'hF, 1'b1, lcdmt_pkg::CODE_HBLANK, 8'd0, 5'b00000},
         {8'd203, 1'b1, 1'b0, 8'd1,   4'hF, 1'b1, lcdmt_pkg::CODE_HBLANK, 8'd0, 5'b00000},
         {8'd1,   1'b1, 1'b0, 8'd1,   4'hF, 1'b1, lcdmt_pkg::CODE_OAM,    8'd1, 5'b11000},
         {8'd79,  1'b1, 1'b0, 8'd0,   4'hF, 1'b1, lcdmt_pkg::CODE_OAM,    8'd1, 5'b10000},
         // no status pulse on the OAM to transfer edge
         {8'd1,   1'b1, 1'b0, 8'd0,   4'hF, 1'b1, lcdmt_pkg::CODE_XFER,   8'd1, 5'b10000},
         {8'd172, 1'b1, 1'b0, 8'd0,   4'h1, 1'b1, lcdmt_pkg::CODE_HBLANK, 8'd1, 5'b11010},
         {8'd172, 1'b1, 1'b0, 8'd0,   4'hE, 1'b0, PREDICTED},
         {8'd255, 1'b1, 1'b0, 8'd2,   4'h0, 1'b0, PREDICTED},
         {8'd255, 1'b1, 1'b0, 8'd0,   4'h0, 1'b0, PREDICTED},
         {8'd0,   1'b1, 1'b0, 8'd0,   4'hF, 1'b0, PREDICTED},
         {8'd100, 1'b1, 1'b1, 8'd0,   4'hF, 1'b0, PREDICTED},
         {8'd255, 1'b0, 1'b0, 8'd0,   4'hF, 1'b0, PREDICTED},
         {8'd255, 1'b1, 1'b0, 8'd3,   4'h8, 1'b0, PREDICTED},
         {8'd255, 1'b1, 1'b0, 8'd255, 4'h4, 1'b0, PREDICTED},
         {8'd255, 1'b1, 1'b0, 8'd255, 4'h0, 1'b0, PREDICTED},
         {8'd255, 1'b1, 1'b0, 8'd255, 4'h0, 1'b0, PREDICTED},
         {8'd0,   1'b0, 1'b1, 8'd0,   4'h0, 1'b0, PREDICTED},
         {8'd0,   1'b1, 1'b0, 8'd0,   4'h0, 1'b0, PREDICTED}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         send_item(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);
      req_bus.valid <= 1'b0;
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         int items;
         lcdmt_pkg::item_type it;
         case (phase)
            1:       next_len = '0;
            2:       next_len = {10'd1, 10'd1, 10'd1, 10'd1};
            3:       next_len = '1;
            4:       next_len = {len_type'($urandom_range(7)), len_type'($urandom_range(7)),
                                 len_type'($urandom_range(7)), len_type'($urandom_range(7))};
            5:       next_len = {len_type'($urandom_range(1023)),
                                 len_type'($urandom_range(1023)),
                                 len_type'($urandom_range(1023)),
                                 len_type'($urandom_range(1023))};
            6:       next_len = {10'd1, 10'd1, 10'd1, 10'd1023};
            default: next_len = {len_type'($urandom_range(15)), len_type'($urandom_range(15)),
                                 len_type'($urandom_range(15)), len_type'($urandom_range(15))};
         endcase
         if (phase != 0) begin
            write_length(lcdmt_pkg::REG_OAM,    next_len.oam_cycles);
            write_length(lcdmt_pkg::REG_XFER,   next_len.xfer_cycles);
            write_length(lcdmt_pkg::REG_HBLANK, next_len.hblank_len);
            write_length(lcdmt_pkg::REG_VBLANK, next_len.vblank_len);
         end
         case (phase % 4)
            0:       begin send_gap_pct = 0;  stall_pct = 0;  end
            1:       begin send_gap_pct = 54; stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  stall_pct = 54; end
            default: begin send_gap_pct = 38; stall_pct = 38; end
         endcase
         items = (phase == 3 || phase == 5) ? 100 : (phase == 0 || phase >= 6) ? 150 : 250;
         for (int n = 0; n < items; n++) begin
            it = random_item();
            send_item(it, 1'b0, PREDICTED);
            random_sent++;
         end
         req_bus.valid <= 1'b0;
         wait_drained();
         send_gap_pct = 0;
         stall_pct = 0;
      end

      repeat (8) @(posedge clock);
      while (pending_results.size() != 0) begin
         report_mismatch("missing transfer", 0, 1);
         void'(pending_results.pop_front());
      end
      $display("Ran %0d table rows and %0d random items over %0d length settings.",
               DIR_ROWS, random_sent, PHASES);
      $display("Checked %0d results: %0d frame ends, %0d vblank entries, %0d restarts.",
               results_seen, frames_seen, vblanks_seen, restarts_sent);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
